>>> rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check sampled on the rising clock, off while reset is held
`define ALG_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// implication form of the same check
`define ALG_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    `ALG_ASSERT(lbl, clk, rst_n, (ante) |=> (cons))

`endif

>>> rtl/alg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package alg_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int AGE_BITS   = 8;

    localparam int X_BITS     = $clog2(MAX_WIDTH);
    localparam int Y_BITS     = $clog2(MAX_HEIGHT);
    localparam int ADDR_BITS  = Y_BITS + X_BITS;
    localparam int CELLS      = MAX_WIDTH * MAX_HEIGHT;
    localparam int DIM_BITS   = 7;
    localparam int COL_BITS   = X_BITS + 1;
    localparam int COUNT_BITS = 13;
    localparam int GEN_BITS   = 16;
    localparam int MAXAGE_BITS = 8;
    localparam int OUT_AGE_BITS = 8;
    localparam int KIND_BITS  = 2;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 8;

    localparam logic [DIM_BITS-1:0]    WIDTH_RESET   = DIM_BITS'(64);
    localparam logic [DIM_BITS-1:0]    HEIGHT_RESET  = DIM_BITS'(64);
    localparam logic [MAXAGE_BITS-1:0] MAX_AGE_RESET = MAXAGE_BITS'(20);
    localparam logic [DIM_BITS-1:0]    DIM_MIN       = DIM_BITS'(3);
    localparam logic [AGE_BITS-1:0]    AGE_MASK      = {AGE_BITS{1'b1}};

    typedef enum logic [KIND_BITS-1:0] {
        KIND_WRITE = 2'd0,
        KIND_STEP  = 2'd1,
        KIND_READ  = 2'd2
    } t_kind;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_WIDTH   = 2'd0,
        CFG_HEIGHT  = 2'd1,
        CFG_MAX_AGE = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_GEN,
        ST_GEN_DRAIN,
        ST_COPY,
        ST_FINISH
    } t_state;

    function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v,
                                                      input logic [DIM_BITS-1:0] hi);
        logic [DIM_BITS-1:0] r;
        if (v < DIM_MIN) r = DIM_MIN;
        else if (v > hi) r = hi;
        else r = v;
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/alg_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module alg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> rtl/aging_life_grid_engine_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// channel | direction | handshake                | payload
// in      | to block  | i_in_valid / o_in_stall  | i_kind i_cell_x i_cell_y i_cell_age
// out     | from block| o_out_valid / i_out_stall| o_read_age o_live_count o_generation
// cfg     | to block  | i_cfg_valid / o_cfg_ready| i_cfg_index i_cfg_data
//
// write and unused kinds: result in the cycle after the item; read: via the grid read register
// step: neighbor reads, three per column over w+2 columns in each of the h rows, through
//   the single grid read port, then the w*h cells of the next grid are copied back
// reset: a clearing pass over all 4096 cells zeroes the grid, items are stalled meanwhile
// one item at a time; an item is taken once the output register is free or being taken

module aging_life_grid_engine_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [alg_pkg::KIND_BITS-1:0]     i_kind,
    input  logic [alg_pkg::X_BITS-1:0]        i_cell_x,
    input  logic [alg_pkg::Y_BITS-1:0]        i_cell_y,
    input  logic [7:0]                        i_cell_age,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [alg_pkg::OUT_AGE_BITS-1:0]  o_read_age,
    output logic [alg_pkg::COUNT_BITS-1:0]    o_live_count,
    output logic [alg_pkg::GEN_BITS-1:0]      o_generation,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [alg_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [alg_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);

    localparam int XB = alg_pkg::X_BITS;
    localparam int YB = alg_pkg::Y_BITS;
    localparam int AB = alg_pkg::ADDR_BITS;
    localparam int GB = alg_pkg::AGE_BITS;
    localparam int CB = alg_pkg::COL_BITS;
    localparam int DB = alg_pkg::DIM_BITS;

    alg_pkg::t_state r_state, n_state;

    // configuration
    logic [DB-1:0]                     r_width, r_height;
    logic [alg_pkg::MAXAGE_BITS-1:0]   r_max_age;

    // sweep counters
    logic [AB-1:0] r_clr_addr;
    logic [YB-1:0] r_y;
    logic [CB-1:0] r_j;
    logic [1:0]    r_r;

    // tag of the read in flight during a generation
    logic          r_t_valid;
    logic [CB-1:0] r_t_j;
    logic [1:0]    r_t_r;
    logic [YB-1:0] r_t_y;

    // 3x3 liveness window: a = left column, b = center column
    logic          r_cb0, r_cb1;
    logic [GB-1:0] r_cb_age;
    logic [2:0]    r_win_a, r_win_b;
    logic [GB-1:0] r_age_b;
    logic [alg_pkg::COUNT_BITS-1:0] r_count;

    // copy-back sweep
    logic [XB-1:0] r_cx;
    logic [YB-1:0] r_cy;
    logic          r_ct_valid;
    logic [AB-1:0] r_ct_addr;

    // results
    logic                              r_out_valid;
    logic [alg_pkg::OUT_AGE_BITS-1:0]  r_read_age;
    logic                              r_rd_inside;
    logic [alg_pkg::COUNT_BITS-1:0]    r_live;
    logic [alg_pkg::GEN_BITS-1:0]      r_gen;

    // fsm strobes
    logic clr_we, gen_issue, copy_issue, rd_done, finish;

    // memory ports
    logic          a_we, n_we;
    logic [AB-1:0] a_waddr, a_raddr, n_waddr, n_raddr;
    logic [GB-1:0] a_wdata, a_rdata, n_wdata, n_rdata;

    logic [DB-1:0] w_eff, h_eff;
    logic [XB-1:0] w_last, x_col;
    logic [YB-1:0] h_last, y_m, y_p, y_row;
    logic          in_acc, in_area, gen_last, copy_last;
    logic [GB-1:0] cap;
    logic          live_in;
    logic [2:0]    col_new;
    logic [3:0]    nbr;
    logic [GB-1:0] nv;
    logic          cell_ready;

    assign w_eff  = alg_pkg::clamp_dim(r_width, DB'(alg_pkg::MAX_WIDTH));
    assign h_eff  = alg_pkg::clamp_dim(r_height, DB'(alg_pkg::MAX_HEIGHT));
    assign w_last = XB'(w_eff - DB'(1));
    assign h_last = YB'(h_eff - DB'(1));
    assign cap    = (r_max_age > alg_pkg::MAXAGE_BITS'(alg_pkg::AGE_MASK))
                    ? alg_pkg::AGE_MASK : GB'(r_max_age);

    assign o_in_stall  = (r_state != alg_pkg::ST_IDLE) || (r_out_valid && i_out_stall);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign in_area     = (DB'(i_cell_x) < w_eff) && (DB'(i_cell_y) < h_eff);
    assign o_cfg_ready = 1'b1;

    // wrapped neighbor rows and column being fetched
    assign y_m   = (r_y == '0) ? h_last : r_y - YB'(1);
    assign y_p   = (r_y == h_last) ? '0 : r_y + YB'(1);
    assign x_col = (r_j == '0) ? w_last
                 : ((r_j == CB'(w_eff) + CB'(1)) ? '0 : XB'(r_j - CB'(1)));

    always_comb begin
        case (r_r)
            2'd0:    y_row = y_m;
            2'd1:    y_row = r_y;
            default: y_row = y_p;
        endcase
    end

    assign gen_last  = (r_r == 2'd2) && (r_j == CB'(w_eff) + CB'(1)) && (r_y == h_last);
    assign copy_last = (r_cx == w_last) && (r_cy == h_last);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            alg_pkg::ST_CLEAR:     if (r_clr_addr == '1) n_state = alg_pkg::ST_IDLE;
            alg_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (i_kind == alg_pkg::KIND_STEP) n_state = alg_pkg::ST_GEN;
                    else if (i_kind == alg_pkg::KIND_READ) n_state = alg_pkg::ST_READ;
                end
            end
            alg_pkg::ST_READ:      n_state = alg_pkg::ST_IDLE;
            alg_pkg::ST_GEN:       if (gen_last) n_state = alg_pkg::ST_GEN_DRAIN;
            alg_pkg::ST_GEN_DRAIN: n_state = alg_pkg::ST_COPY;
            alg_pkg::ST_COPY:      if (copy_last) n_state = alg_pkg::ST_FINISH;
            alg_pkg::ST_FINISH:    n_state = alg_pkg::ST_IDLE;
            default:               n_state = alg_pkg::ST_IDLE;
        endcase
    end

    // fsm outputs
    always_comb begin
        clr_we     = 1'b0;
        gen_issue  = 1'b0;
        copy_issue = 1'b0;
        rd_done    = 1'b0;
        finish     = 1'b0;
        case (r_state)
            alg_pkg::ST_CLEAR:  clr_we     = 1'b1;
            alg_pkg::ST_GEN:    gen_issue  = 1'b1;
            alg_pkg::ST_COPY:   copy_issue = 1'b1;
            alg_pkg::ST_READ:   rd_done    = 1'b1;
            alg_pkg::ST_FINISH: finish     = 1'b1;
            default: ;
        endcase
    end

    // grid port muxing: clear, copy-back and item write never overlap
    always_comb begin
        a_we    = 1'b0;
        a_waddr = {i_cell_y, i_cell_x};
        a_wdata = i_cell_age[GB-1:0];
        if (clr_we) begin
            a_we    = 1'b1;
            a_waddr = r_clr_addr;
            a_wdata = '0;
        end else if (r_ct_valid) begin
            a_we    = 1'b1;
            a_waddr = r_ct_addr;
            a_wdata = n_rdata;
        end else if (in_acc && i_kind == alg_pkg::KIND_WRITE && in_area) begin
            a_we = 1'b1;
        end
    end

    assign a_raddr = gen_issue ? {y_row, x_col} : {i_cell_y, i_cell_x};
    assign n_raddr = {r_cy, r_cx};

    // new cell from the window once its right column has arrived
    assign live_in = (a_rdata != '0);
    assign col_new = {live_in, r_cb1, r_cb0};
    assign nbr = 4'(r_win_a[0]) + 4'(r_win_a[1]) + 4'(r_win_a[2])
               + 4'(r_win_b[0]) + 4'(r_win_b[2])
               + 4'(col_new[0]) + 4'(col_new[1]) + 4'(col_new[2]);
    always_comb begin
        nv = '0;
        if (nbr == 4'd3 || (r_age_b != '0 && nbr == 4'd2)) begin
            nv = (r_age_b < cap) ? r_age_b + GB'(1) : cap;
        end
    end
    assign cell_ready = r_t_valid && (r_t_r == 2'd2) && (r_t_j >= CB'(2));
    assign n_we    = cell_ready;
    assign n_waddr = {r_t_y, XB'(r_t_j - CB'(2))};
    assign n_wdata = nv;

    alg_ram #(.WIDTH(GB), .DEPTH(alg_pkg::CELLS)) u_age_ram (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (a_waddr),
        .i_wdata (a_wdata),
        .i_raddr (a_raddr),
        .o_rdata (a_rdata)
    );

    alg_ram #(.WIDTH(GB), .DEPTH(alg_pkg::CELLS)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (n_we),
        .i_waddr (n_waddr),
        .i_wdata (n_wdata),
        .i_raddr (n_raddr),
        .o_rdata (n_rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= alg_pkg::ST_CLEAR;
            r_width     <= alg_pkg::WIDTH_RESET;
            r_height    <= alg_pkg::HEIGHT_RESET;
            r_max_age   <= alg_pkg::MAX_AGE_RESET;
            r_clr_addr  <= '0;
            r_t_valid   <= 1'b0;
            r_ct_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_live      <= '0;
            r_gen       <= '0;
        end else begin
            r_state    <= n_state;
            r_t_valid  <= gen_issue;
            r_ct_valid <= copy_issue;
            if (clr_we) r_clr_addr <= r_clr_addr + AB'(1);

            if (i_cfg_valid) begin
                case (i_cfg_index)
                    alg_pkg::CFG_WIDTH:   r_width   <= i_cfg_data[DB-1:0];
                    alg_pkg::CFG_HEIGHT:  r_height  <= i_cfg_data[DB-1:0];
                    alg_pkg::CFG_MAX_AGE: r_max_age <= i_cfg_data;
                    default: ;
                endcase
            end

            if (finish) begin
                r_out_valid <= 1'b1;
                r_live      <= r_count;
                r_gen       <= r_gen + alg_pkg::GEN_BITS'(1);
            end else if (rd_done) begin
                r_out_valid <= 1'b1;
            end else if (in_acc && i_kind != alg_pkg::KIND_STEP
                         && i_kind != alg_pkg::KIND_READ) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rd_inside <= in_area;
            r_y   <= '0;
            r_j   <= '0;
            r_r   <= '0;
            r_cx  <= '0;
            r_cy  <= '0;
            r_count <= '0;
        end
        if (gen_issue) begin
            r_t_j <= r_j;
            r_t_r <= r_r;
            r_t_y <= r_y;
            if (r_r == 2'd2) begin
                r_r <= '0;
                if (r_j == CB'(w_eff) + CB'(1)) begin
                    r_j <= '0;
                    r_y <= r_y + YB'(1);
                end else begin
                    r_j <= r_j + CB'(1);
                end
            end else begin
                r_r <= r_r + 2'd1;
            end
        end
        if (r_t_valid) begin
            case (r_t_r)
                2'd0: r_cb0 <= live_in;
                2'd1: begin
                    r_cb1    <= live_in;
                    r_cb_age <= a_rdata;
                end
                default: begin
                    r_win_a <= r_win_b;
                    r_win_b <= col_new;
                    r_age_b <= r_cb_age;
                end
            endcase
        end
        if (cell_ready && nv != '0 && r_count != '1) begin
            r_count <= r_count + alg_pkg::COUNT_BITS'(1);
        end
        if (copy_issue) begin
            r_ct_addr <= {r_cy, r_cx};
            if (r_cx == w_last) begin
                r_cx <= '0;
                r_cy <= r_cy + YB'(1);
            end else begin
                r_cx <= r_cx + XB'(1);
            end
        end
        if (finish) begin
            r_read_age <= '0;
        end else if (rd_done) begin
            r_read_age <= r_rd_inside ? alg_pkg::OUT_AGE_BITS'(a_rdata) : '0;
        end else if (in_acc && i_kind != alg_pkg::KIND_STEP
                     && i_kind != alg_pkg::KIND_READ) begin
            r_read_age <= '0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_age   = r_read_age;
    assign o_live_count = r_live;
    assign o_generation = r_gen;

endmodule

`default_nettype wire

>>> rtl/alg_chk.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module alg_chk (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              i_in_valid,
    input wire                              o_in_stall,
    input wire [alg_pkg::KIND_BITS-1:0]     i_kind,
    input wire                              o_out_valid,
    input wire                              i_out_stall,
    input wire [alg_pkg::OUT_AGE_BITS-1:0]  o_read_age,
    input wire [alg_pkg::GEN_BITS-1:0]      o_generation
);

    // a held result stays offered
    `ALG_ASSERT_IMPL(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)

    // a held result keeps its age
    `ALG_ASSERT_IMPL(a_age_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_read_age))

    // a write item answers in the next cycle with age zero
    `ALG_ASSERT_IMPL(a_write_resp, i_clk, i_rst_n,
        i_in_valid && !o_in_stall && i_kind == alg_pkg::KIND_WRITE,
        o_out_valid && o_read_age == '0)

    // the generation count only ever steps by one
    `ALG_ASSERT(a_gen_step, i_clk, i_rst_n,
        !$stable(o_generation) |-> o_generation == $past(o_generation) + 16'd1)

endmodule

bind aging_life_grid_engine_unit alg_chk u_alg_chk (.*);

`default_nettype wire
